[rtl/core/dmn_pkg.sv]
package dmn_pkg;

    localparam logic [1:0] REQ_LOCAL   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_PEER    = 2'd2;
    localparam logic [1:0] REQ_REPLY   = 2'd3;

    localparam logic [1:0] MSG_NONE  = 2'd0;
    localparam logic [1:0] MSG_BCAST = 2'd1;
    localparam logic [1:0] MSG_REPLY = 2'd2;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_REQ  = 2'd1;
    localparam logic [1:0] MODE_CS   = 2'd2;

    localparam logic REG_OWN_ID     = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;

    localparam logic [3:0] OWN_ID_RST     = 4'd0;
    localparam logic [4:0] NODE_COUNT_RST = 5'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  peer_id;
        logic [31:0] peer_clock;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  msg_kind;
        logic [3:0]  dest_node;
        logic [31:0] msg_clock;
        logic [1:0]  node_state;
        logic        accepted;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [3:0] own_id;
        logic [4:0] node_count;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic rel_scan;
        logic scan_hit;
        logic scan_last;
    } t_dp_status;

endpackage

[rtl/core/dmn_cfg.sv]
module dmn_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output dmn_pkg::t_cfg       o_cfg
);
    import dmn_pkg::*;

    t_cfg r_cfg;

    // register index sits at byte address bit 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_id     <= OWN_ID_RST;
            r_cfg.node_count <= NODE_COUNT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_OWN_ID:     r_cfg.own_id     <= pwdata[3:0];
                REG_NODE_COUNT: r_cfg.node_count <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_OWN_ID:     prdata = {28'd0, r_cfg.own_id};
            REG_NODE_COUNT: prdata = {27'd0, r_cfg.node_count};
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

[rtl/core/dmn_ctrl.sv]
module dmn_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  dmn_pkg::t_dp_status   i_status,
    output dmn_pkg::t_dp_cmd      o_cmd
);
    import dmn_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;
    logic   n_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_status.rel_scan ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN: begin
                // empty slots are skipped even while the output is held
                o_cmd.scan = i_status.out_free || !i_status.scan_hit;
                if (i_status.out_free && i_status.scan_hit && i_status.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_stall = r_stall;

endmodule

[rtl/core/dmn_dp.sv]
module dmn_dp #(
    parameter int MAX_NODES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dmn_pkg::t_cfg         i_cfg,
    input  dmn_pkg::t_in_item     i_data,
    input  logic                  i_stall,
    output logic                  o_valid,
    output dmn_pkg::t_out_item    o_data,
    input  dmn_pkg::t_dp_cmd      i_cmd,
    output dmn_pkg::t_dp_status   o_status
);
    import dmn_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int RW  = $clog2(MAX_NODES);
    localparam int EW0 = $clog2(MAX_NODES + 1);
    localparam int EW  = (EW0 > 5) ? EW0 : 5;

    // protocol state
    logic [31:0]          r_clock;
    logic [31:0]          r_stamp;
    logic [1:0]           r_mode;
    logic [RW-1:0]        r_count;
    logic [MAX_NODES-1:0] r_defer;

    logic [31:0]          n_clock;
    logic [31:0]          n_stamp;
    logic [1:0]           n_mode;
    logic [RW-1:0]        n_count;
    logic [MAX_NODES-1:0] n_defer;

    // release scan
    logic [MAX_NODES-1:0] r_scan;
    logic [NW-1:0]        r_idx;

    t_in_item             r_in;
    t_out_item            r_out;
    logic                 r_out_valid;

    logic [EW-1:0]        eff_n;
    logic [EW-1:0]        cnt_inc;
    logic                 peer_ok;
    logic                 defer;
    logic [31:0]          clk_inc;
    logic [31:0]          clk_max;
    logic [31:0]          merged;
    logic [31:0]          merged_inc;
    logic [MAX_NODES-1:0] own_mask;
    logic [MAX_NODES-1:0] pid_mask;
    logic [MAX_NODES-1:0] idx_mask;
    logic [MAX_NODES-1:0] pend;
    logic [MAX_NODES-1:0] scan_clr;
    logic                 rel_scan;
    logic                 scan_hit;
    logic                 scan_last;
    logic                 out_free;
    t_out_item            res_exec;
    t_out_item            res_scan;

    always_comb begin
        if (EW'(i_cfg.node_count) < EW'(2)) begin
            eff_n = EW'(2);
        end else if (EW'(i_cfg.node_count) > EW'(MAX_NODES)) begin
            eff_n = EW'(MAX_NODES);
        end else begin
            eff_n = EW'(i_cfg.node_count);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            own_mask[i] = (int'(i_cfg.own_id) == i);
            pid_mask[i] = (int'(r_in.peer_id) == i);
            idx_mask[i] = (r_idx == NW'(i));
        end
    end

    assign peer_ok    = (r_in.peer_id != i_cfg.own_id) && (EW'(r_in.peer_id) < eff_n);
    assign clk_inc    = r_clock + 32'd1;
    assign clk_max    = (r_clock > r_in.peer_clock) ? r_clock : r_in.peer_clock;
    assign merged     = clk_max + 32'd1;
    assign merged_inc = clk_max + 32'd2;
    assign cnt_inc    = EW'(r_count) + EW'(1);
    assign pend       = r_defer & ~own_mask;

    // lower (stamp, id) pair wins; in section always defers
    assign defer = (r_mode == MODE_CS) ||
                   ((r_mode == MODE_REQ) &&
                    ((r_stamp < r_in.peer_clock) ||
                     ((r_stamp == r_in.peer_clock) && (i_cfg.own_id < r_in.peer_id))));

    always_comb begin
        n_clock             = r_clock;
        n_stamp             = r_stamp;
        n_mode              = r_mode;
        n_count             = r_count;
        n_defer             = r_defer;
        rel_scan            = 1'b0;
        res_exec            = '0;
        res_exec.msg_kind   = MSG_NONE;
        res_exec.node_state = r_mode;
        res_exec.last       = 1'b1;
        case (r_in.req_type)
            REQ_LOCAL: begin
                if (r_mode == MODE_IDLE) begin
                    n_clock             = clk_inc;
                    n_stamp             = clk_inc;
                    n_mode              = MODE_REQ;
                    n_count             = '0;
                    res_exec.msg_kind   = MSG_BCAST;
                    res_exec.msg_clock  = clk_inc;
                    res_exec.accepted   = 1'b1;
                    res_exec.node_state = MODE_REQ;
                end
            end
            REQ_RELEASE: begin
                if (r_mode == MODE_CS) begin
                    n_clock             = clk_inc;
                    n_defer             = '0;
                    n_mode              = MODE_IDLE;
                    n_count             = '0;
                    res_exec.accepted   = 1'b1;
                    res_exec.node_state = MODE_IDLE;
                    rel_scan            = |pend;
                end
            end
            REQ_PEER: begin
                if (peer_ok) begin
                    n_clock           = merged;
                    res_exec.accepted = 1'b1;
                    if (defer) begin
                        n_defer = r_defer | pid_mask;
                    end else begin
                        n_clock            = merged_inc;
                        res_exec.msg_kind  = MSG_REPLY;
                        res_exec.dest_node = r_in.peer_id;
                        res_exec.msg_clock = merged_inc;
                    end
                end
            end
            default: begin
                if (peer_ok && (r_mode == MODE_REQ)) begin
                    n_clock = merged;
                    n_count = RW'(cnt_inc);
                    if (cnt_inc >= (eff_n - EW'(1))) begin
                        n_mode = MODE_CS;
                    end
                    res_exec.accepted   = 1'b1;
                    res_exec.node_state = n_mode;
                end
            end
        endcase
    end

    assign scan_hit  = r_scan[r_idx];
    assign scan_clr  = r_scan & ~idx_mask;
    assign scan_last = (scan_clr == '0);
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        res_scan            = '0;
        res_scan.msg_kind   = MSG_REPLY;
        res_scan.dest_node  = 4'(r_idx);
        res_scan.msg_clock  = r_clock;
        res_scan.node_state = r_mode;
        res_scan.accepted   = 1'b1;
        res_scan.last       = scan_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock     <= '0;
            r_stamp     <= '0;
            r_mode      <= MODE_IDLE;
            r_count     <= '0;
            r_defer     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_clock <= n_clock;
                r_stamp <= n_stamp;
                r_mode  <= n_mode;
                r_count <= n_count;
                r_defer <= n_defer;
                r_idx   <= '0;
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + NW'(1);
            end
            if ((i_cmd.exec && !rel_scan) || (i_cmd.scan && scan_hit)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_data;
        end
        if (i_cmd.exec) begin
            r_scan <= pend;
        end else if (i_cmd.scan && scan_hit) begin
            r_scan <= scan_clr;
        end
        if (i_cmd.exec && !rel_scan) begin
            r_out <= res_exec;
        end else if (i_cmd.scan && scan_hit) begin
            r_out <= res_scan;
        end
    end

    always_comb begin
        o_status.out_free  = out_free;
        o_status.rel_scan  = rel_scan;
        o_status.scan_hit  = scan_hit;
        o_status.scan_last = scan_last;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[rtl/core/distributed_mutex_node_unit.sv]
// One node of a Ricart-Agrawala mutual exclusion scheme with a Lamport clock.
// Input channel (i_valid / o_stall, payload i_data): local request, local
// release, received peer request or received peer reply. Output channel
// (o_valid / i_stall, payload o_data): one or more results per input item,
// the final one flagged by last. own_id and node_count are written through
// the APB port at byte addresses 0 and 4; pready is tied high.
// Timing: an item is loaded in the idle state; the execute state waits for a
// free output register and writes the result into it. A release with
// deferred peers scans the deferred bitmap one slot per cycle, pausing on a
// set slot while the output is held, giving one reply per set slot. The
// bitmap scan sets the release length; other items end in the execute state.
// The output register lets a new item be taken while a result still waits.
// If the receiver stalls, the result holds and the next result waits for it.
// Reset (synchronous, active low) clears the clock, the stamp, the reply
// count and the deferred bitmap, puts the node in idle, and sets own_id to 0
// and node_count to 2.
module distributed_mutex_node_unit #(
    parameter int MAX_NODES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  dmn_pkg::t_in_item     i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output dmn_pkg::t_out_item    o_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import dmn_pkg::*;

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    dmn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dmn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dmn_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_data   (i_data),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_data   (o_data),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

[tb/dmn_checker.sv]
`timescale 1ns / 100ps

// Watches both channels and the register port of one mutex node, keeps its own
// copy of the node state, predicts every result and compares field by field.
module dmn_checker #(
    parameter int MAX_NODES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  dmn_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  dmn_pkg::t_out_item i_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    output int                 o_err_count,
    output int                 o_pending
);
    import dmn_pkg::*;

    localparam logic [2:0] ADDR_OWN_ID     = {REG_OWN_ID, 2'b00};
    localparam logic [2:0] ADDR_NODE_COUNT = {REG_NODE_COUNT, 2'b00};

    logic [31:0] lamport;
    logic [31:0] req_stamp;
    logic [1:0]  node_mode;
    int          replies;
    logic [15:0] deferred;
    logic [3:0]  cfg_own;
    logic [4:0]  cfg_nodes;
    int          errors = 0;
    t_out_item   expected_msgs[$];
    t_out_item   want;
    logic [31:0] reg_value;

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // node_state is taken from the mode as it stands after the update
    task automatic push_msg(input logic [1:0] kind, input logic [3:0] dest,
                            input logic [31:0] stamp, input logic acc, input logic fin);
        t_out_item m;
        m.msg_kind   = kind;
        m.dest_node  = dest;
        m.msg_clock  = stamp;
        m.node_state = node_mode;
        m.accepted   = acc;
        m.last       = fin;
        expected_msgs.push_back(m);
    endtask

    task automatic merge_clock(input logic [31:0] pc);
        lamport = ((lamport > pc) ? lamport : pc) + 32'd1;
    endtask

    task automatic advance_node(input t_in_item it);
        int          n;
        logic        peer_ok;
        logic        defer;
        logic [15:0] pend;
        n = (cfg_nodes < 2) ? 2 : ((cfg_nodes > MAX_NODES) ? MAX_NODES : int'(cfg_nodes));
        peer_ok = (it.peer_id != cfg_own) && (int'(it.peer_id) < n);
        case (it.req_type)
            REQ_LOCAL: begin
                if (node_mode != MODE_IDLE) begin
                    push_msg(MSG_NONE, 4'd0, 32'd0, 1'b0, 1'b1);
                end else begin
                    lamport   = lamport + 32'd1;
                    req_stamp = lamport;
                    node_mode = MODE_REQ;
                    replies   = 0;
                    push_msg(MSG_BCAST, 4'd0, lamport, 1'b1, 1'b1);
                end
            end
            REQ_RELEASE: begin
                if (node_mode != MODE_CS) begin
                    push_msg(MSG_NONE, 4'd0, 32'd0, 1'b0, 1'b1);
                end else begin
                    lamport   = lamport + 32'd1;
                    // a deferred bit at our own id gets no reply
                    pend      = deferred & ~(16'd1 << cfg_own);
                    deferred  = '0;
                    node_mode = MODE_IDLE;
                    replies   = 0;
                    if (pend == '0) begin
                        push_msg(MSG_NONE, 4'd0, 32'd0, 1'b1, 1'b1);
                    end else begin
                        for (int i = 0; i < 16; i++) begin
                            if (pend[i]) begin
                                pend[i] = 1'b0;
                                push_msg(MSG_REPLY, 4'(i), lamport, 1'b1, pend == '0);
                            end
                        end
                    end
                end
            end
            REQ_PEER: begin
                if (!peer_ok) begin
                    push_msg(MSG_NONE, 4'd0, 32'd0, 1'b0, 1'b1);
                end else begin
                    merge_clock(it.peer_clock);
                    defer = (node_mode == MODE_CS) ||
                            (node_mode == MODE_REQ &&
                             (req_stamp < it.peer_clock ||
                              (req_stamp == it.peer_clock && cfg_own < it.peer_id)));
                    if (defer) begin
                        deferred[it.peer_id] = 1'b1;
                        push_msg(MSG_NONE, 4'd0, 32'd0, 1'b1, 1'b1);
                    end else begin
                        lamport = lamport + 32'd1;
                        push_msg(MSG_REPLY, it.peer_id, lamport, 1'b1, 1'b1);
                    end
                end
            end
            default: begin
                if (!peer_ok || node_mode != MODE_REQ) begin
                    push_msg(MSG_NONE, 4'd0, 32'd0, 1'b0, 1'b1);
                end else begin
                    merge_clock(it.peer_clock);
                    replies++;
                    if (replies >= n - 1) node_mode = MODE_CS;
                    push_msg(MSG_NONE, 4'd0, 32'd0, 1'b1, 1'b1);
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lamport   = '0;
            req_stamp = '0;
            node_mode = MODE_IDLE;
            replies   = 0;
            deferred  = '0;
            cfg_own   = OWN_ID_RST;
            cfg_nodes = NODE_COUNT_RST;
            expected_msgs.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_msgs.size() == 0) begin
                    $error("unexpected result transfer: %p", i_out_data);
                    errors++;
                end else begin
                    want = expected_msgs.pop_front();
                    check_field("msg_kind", 32'(want.msg_kind), 32'(i_out_data.msg_kind));
                    check_field("dest_node", 32'(want.dest_node),
                                32'(i_out_data.dest_node));
                    check_field("msg_clock", want.msg_clock, i_out_data.msg_clock);
                    check_field("node_state", 32'(want.node_state),
                                32'(i_out_data.node_state));
                    check_field("accepted", 32'(want.accepted), 32'(i_out_data.accepted));
                    check_field("last", 32'(want.last), 32'(i_out_data.last));
                end
            end
            if (i_in_valid && !i_in_stall) advance_node(i_in_data);
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == ADDR_OWN_ID) cfg_own = pwdata[3:0];
                    else if (paddr == ADDR_NODE_COUNT) cfg_nodes = pwdata[4:0];
                end else begin
                    reg_value = (paddr == ADDR_OWN_ID) ? {28'd0, cfg_own} : {27'd0, cfg_nodes};
                    check_field("prdata", reg_value, prdata);
                end
            end
        end
        o_err_count <= errors;
        o_pending   <= expected_msgs.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import dmn_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int ITEMS_PER_PHASE = 28;

    localparam logic [2:0] ADDR_OWN_ID     = {REG_OWN_ID, 2'b00};
    localparam logic [2:0] ADDR_NODE_COUNT = {REG_NODE_COUNT, 2'b00};

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_in_item    i_data  = '0;
    logic        i_stall = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;

    logic        o_stall;
    logic        o_valid;
    t_out_item   o_data;
    logic [31:0] prdata;
    logic        pready;

    int          err_count;
    int          pending;
    int          tx_idle_pct = 27;
    int          rx_idle_pct = 45;
    int          idle_cycles = 0;
    int          seq_items   = 0;
    int          eff_nodes   = 2;
    logic [3:0]  own_id_cfg  = OWN_ID_RST;
    logic [31:0] clock_hint  = '0;
    int          phase_end;

    distributed_mutex_node_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dmn_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_data  (o_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // peer clocks are aimed near the node's recent clock so tie and order cases occur
    always @(posedge i_clk) begin
        if (o_valid && !i_stall && o_data.msg_kind != MSG_NONE) clock_hint <= o_data.msg_clock;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [3:0] pid,
                             input logic [31:0] pc);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{req_type: kind, peer_id: pid, peer_clock: pc};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // a random junk transfer now and then ahead of a protocol step
    task automatic send_seq(input logic [1:0] kind, input logic [3:0] pid,
                            input logic [31:0] pc);
        if ($urandom_range(0, 99) < 8)
            send_item(2'($urandom), 4'($urandom), $urandom);
        send_item(kind, pid, pc);
        seq_items++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [3:0] own, input logic [4:0] nodes);
        drain();
        apb_access(1'b1, ADDR_OWN_ID, {28'd0, own});
        apb_access(1'b1, ADDR_NODE_COUNT, {27'd0, nodes});
        apb_access(1'b0, ADDR_OWN_ID, '0);
        apb_access(1'b0, ADDR_NODE_COUNT, '0);
        own_id_cfg = own;
        eff_nodes  = (nodes < 2) ? 2 : ((nodes > 16) ? 16 : int'(nodes));
    endtask

    function automatic logic [3:0] pick_peer();
        logic [3:0] id;
        do id = 4'($urandom_range(0, eff_nodes - 1)); while (id == own_id_cfg);
        return id;
    endfunction

    function automatic logic [31:0] rand_clock();
        case ($urandom_range(0, 11))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 2);
            default: return clock_hint - 32'd3 + $urandom_range(0, 6);
        endcase
    endfunction

    task automatic random_config();
        logic [3:0] own;
        logic [4:0] nodes;
        own = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0:       nodes = 5'($urandom_range(0, 1));
            1, 2:    nodes = 5'($urandom_range(16, 31));
            default: nodes = 5'($urandom_range(2, 6));
        endcase
        set_config(own, nodes);
    endtask

    // request, collect replies with peer requests mixed in, hold the section, release
    task automatic mutex_round();
        int extra;
        send_seq(REQ_LOCAL, 4'($urandom), $urandom);
        for (int r = 0; r < eff_nodes - 1; r++) begin
            while ($urandom_range(0, 99) < 30) send_seq(REQ_PEER, pick_peer(), rand_clock());
            send_seq(REQ_REPLY, pick_peer(), rand_clock());
        end
        extra = $urandom_range(0, 3);
        repeat (extra) send_seq(REQ_PEER, pick_peer(), rand_clock());
        send_seq(REQ_RELEASE, 4'($urandom), $urandom);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of both registers
        apb_access(1'b0, ADDR_OWN_ID, '0);
        apb_access(1'b0, ADDR_NODE_COUNT, '0);

        // own id 0, two nodes: illegal items, clock wrap, tie break, one deferred reply
        send_item(REQ_RELEASE, 4'd0, 32'd0);
        send_item(REQ_REPLY, 4'd1, 32'd0);
        send_item(REQ_PEER, 4'd0, 32'd5);
        send_item(REQ_PEER, 4'd5, 32'd5);
        send_item(REQ_PEER, 4'd1, 32'hFFFF_FFFF);
        send_item(REQ_LOCAL, 4'd15, 32'hFFFF_FFFF);
        send_item(REQ_LOCAL, 4'd0, 32'd0);
        send_item(REQ_PEER, 4'd1, 32'd2);
        send_item(REQ_REPLY, 4'd1, 32'd0);
        send_item(REQ_REPLY, 4'd1, 32'd0);
        send_item(REQ_LOCAL, 4'd0, 32'd0);
        send_item(REQ_RELEASE, 4'd0, 32'd0);
        send_item(REQ_RELEASE, 4'd0, 32'd0);

        // own id 15, node count above the maximum
        set_config(4'd15, 5'd31);
        send_item(REQ_LOCAL, 4'd0, 32'd0);
        send_item(REQ_PEER, 4'd3, 32'd0);
        send_item(REQ_PEER, 4'd14, 32'hFFFF_FFFF);
        send_item(REQ_PEER, 4'd15, 32'd0);
        send_item(REQ_REPLY, 4'd15, 32'd0);

        // three nodes while still requesting; duplicate replies count
        set_config(4'd2, 5'd3);
        send_item(REQ_REPLY, 4'd0, 32'd7);
        send_item(REQ_REPLY, 4'd0, 32'd7);
        send_item(REQ_PEER, 4'd1, 32'd0);
        send_item(REQ_PEER, 4'd0, 32'd0);

        // own id moves onto a deferred peer: that one gets no reply on release
        set_config(4'd1, 5'd0);
        send_item(REQ_RELEASE, 4'd0, 32'd0);

        for (int p = 0; p < 3; p++) begin
            drain();
            tx_idle_pct = (p == 0) ? 27 : ((p == 1) ? 45 : 0);
            rx_idle_pct = (p == 0) ? 45 : ((p == 1) ? 27 : 0);
            random_config();
            phase_end = seq_items + ITEMS_PER_PHASE;
            while (seq_items < phase_end) begin
                if ($urandom_range(0, 2) == 0) random_config();
                mutex_round();
            end
        end

        drain();
        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
